/* hdl/assert_macros.svh */
// Assertion macros shared by the framer RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on the rising clock edge, ignored while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check against the default clock and reset names.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLK(label, clk, rst, prop, msg)

`endif

/* hdl/isf_pkg.sv */
// Package for the information-frame stuffing framer: payload structs,
// register index codes, emit phase codes and reset values. No dependencies.
package isf_pkg;

  localparam int ByteWidth = 8;
  localparam int SeqShift  = 6;

  localparam logic [ByteWidth-1:0] FlagReset    = 8'd126;
  localparam logic [ByteWidth-1:0] EscapeReset  = 8'd125;
  localparam logic [ByteWidth-1:0] MaskReset    = 8'd32;
  localparam logic [ByteWidth-1:0] AddressReset = 8'd3;

  typedef struct packed {
    logic [ByteWidth-1:0] data_byte;
    logic                 end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [ByteWidth-1:0] out_byte;
    logic                 frame_end;
  } out_item_t;

  typedef enum logic [1:0] {
    REG_FLAG    = 2'd0,
    REG_ESCAPE  = 2'd1,
    REG_MASK    = 2'd2,
    REG_ADDRESS = 2'd3
  } cfg_reg_t;

  // Which byte of the current request goes out next
  typedef enum logic [3:0] {
    PH_FLAG     = 4'd0,
    PH_ADDR     = 4'd1,
    PH_CTRL     = 4'd2,
    PH_HCHK     = 4'd3,
    PH_DATA     = 4'd4,
    PH_DATA_ESC = 4'd5,
    PH_CHK      = 4'd6,
    PH_CHK_ESC  = 4'd7,
    PH_CLOSE    = 4'd8
  } phase_t;

endpackage

/* hdl/info_frame_stuffing_framer_core.sv */
// An accepted request is held and its bytes go out through the single output
// register, one output byte per cycle while the output is not stalled. A request
// yields 1 or 2 bytes for its payload byte, 4 more when it opens a frame and
// 2 or 3 more when it closes one, 9 at most. Next request is taken as the last
// byte of the current one goes out. Synchronous reset restores config registers,
// closes any frame, clears seq and check.
`include "assert_macros.svh"

module info_frame_stuffing_framer_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  isf_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output isf_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  isf_pkg::cfg_reg_t   cfg_index,
  input  logic [7:0]          cfg_data
);
  import isf_pkg::*;

  // Configuration registers
  logic [ByteWidth-1:0] flag_value;
  logic [ByteWidth-1:0] escape_value;
  logic [ByteWidth-1:0] stuff_mask;
  logic [ByteWidth-1:0] address_value;

  // Frame state
  logic                 inside_frame;
  logic                 sequence_bit;
  logic [ByteWidth-1:0] running_check;

  // Held request and emit phase
  logic                 hold;
  in_item_t             item;
  phase_t               phase;
  phase_t               phase_next;

  // Emit path
  logic                 emit;
  logic                 done;
  logic [ByteWidth-1:0] ctrl;
  logic [ByteWidth-1:0] check;
  logic                 data_rsvd;
  logic                 check_rsvd;
  out_item_t            emit_item;
  logic                 inside_frame_next;

  assign cfg_ready = 1'b1;

  // Write the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_value    <= FlagReset;
      escape_value  <= EscapeReset;
      stuff_mask    <= MaskReset;
      address_value <= AddressReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FLAG:    flag_value    <= cfg_data;
        REG_ESCAPE:  escape_value  <= cfg_data;
        REG_MASK:    stuff_mask    <= cfg_data;
        REG_ADDRESS: address_value <= cfg_data;
        default:     ;
      endcase
    end
  end

  assign ctrl       = ByteWidth'({7'd0, sequence_bit}) << SeqShift;
  assign check      = running_check ^ item.data_byte;
  assign data_rsvd  = (item.data_byte == flag_value) || (item.data_byte == escape_value);
  assign check_rsvd = (check == flag_value) || (check == escape_value);
  assign emit       = hold && (!out_valid || out_ready);

  // Pick the byte for this phase and the phase that follows
  always_comb begin
    emit_item  = '{out_byte: flag_value, frame_end: 1'b0};
    phase_next = phase;
    done       = 1'b0;
    case (phase)
      PH_FLAG: begin
        phase_next = PH_ADDR;
      end
      PH_ADDR: begin
        emit_item.out_byte = address_value;
        phase_next         = PH_CTRL;
      end
      PH_CTRL: begin
        emit_item.out_byte = ctrl;
        phase_next         = PH_HCHK;
      end
      PH_HCHK: begin
        emit_item.out_byte = address_value ^ ctrl;
        phase_next         = PH_DATA;
      end
      PH_DATA: begin
        if (data_rsvd) begin
          emit_item.out_byte = escape_value;
          phase_next         = PH_DATA_ESC;
        end else begin
          emit_item.out_byte = item.data_byte;
          phase_next         = PH_CHK;
          done               = !item.end_of_packet;
        end
      end
      PH_DATA_ESC: begin
        emit_item.out_byte = item.data_byte ^ stuff_mask;
        phase_next         = PH_CHK;
        done               = !item.end_of_packet;
      end
      PH_CHK: begin
        if (check_rsvd) begin
          emit_item.out_byte = escape_value;
          phase_next         = PH_CHK_ESC;
        end else begin
          emit_item.out_byte = check;
          phase_next         = PH_CLOSE;
        end
      end
      PH_CHK_ESC: begin
        emit_item.out_byte = check ^ stuff_mask;
        phase_next         = PH_CLOSE;
      end
      PH_CLOSE: begin
        emit_item.frame_end = 1'b1;
        done                = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
    done = done && emit;
  end

  assign in_ready          = !hold || done;
  assign inside_frame_next = done ? !item.end_of_packet : inside_frame;

  // Advance frame state as a request completes
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame  <= 1'b0;
      sequence_bit  <= 1'b0;
      running_check <= '0;
    end else if (done) begin
      inside_frame <= !item.end_of_packet;
      if (item.end_of_packet) begin
        sequence_bit  <= !sequence_bit;
        running_check <= '0;
      end else begin
        running_check <= check;
      end
    end
  end

  // Hold the current request and step through its bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      hold  <= 1'b0;
      phase <= PH_FLAG;
    end else if (in_valid && in_ready) begin
      hold  <= 1'b1;
      phase <= inside_frame_next ? PH_DATA : PH_FLAG;
    end else if (done) begin
      hold <= 1'b0;
    end else if (emit) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= emit_item;
    end
  end

  // Header bytes only ever go out for a frame that is not yet open
  `ASSERT_STD(a_header_outside_frame,
    hold && (phase == PH_FLAG || phase == PH_ADDR || phase == PH_CTRL || phase == PH_HCHK)
      |-> !inside_frame,
    "header phase inside open frame")
  // Closing a packet clears the check and closes the frame
  `ASSERT_STD(a_close_clears,
    done && item.end_of_packet |=> !inside_frame && running_check == '0,
    "frame state not cleared at packet end")
  // A byte is emitted only while a request is held
  `ASSERT_STD(a_emit_needs_hold,
    !hold |=> !out_valid || $past(out_valid && !out_ready),
    "output byte without a request")

endmodule

/* verif/info_frame_stuffing_framer_core_tb.sv */
`timescale 1ns / 1ps
// Testbench for info_frame_stuffing_framer_core: a frame predictor checks every output
// byte in order. Depends on isf_pkg and the framer core RTL only.

module info_frame_stuffing_framer_core_tb;
  import isf_pkg::*;

  // Predict the framed, stuffed byte stream and check the block's output against it
  class framer_scoreboard;
    logic [ByteWidth-1:0] flag_byte;
    logic [ByteWidth-1:0] escape_byte;
    logic [ByteWidth-1:0] mask_byte;
    logic [ByteWidth-1:0] addr_byte;
    bit                   in_frame;
    bit                   seq_bit;
    logic [ByteWidth-1:0] payload_xor;
    out_item_t            expected_bytes[$];
    int                   mismatches;
    int                   requests;
    int                   out_bytes;
    int                   frames;
    int                   reg_writes;

    function new();
      flag_byte   = FlagReset;
      escape_byte = EscapeReset;
      mask_byte   = MaskReset;
      addr_byte   = AddressReset;
      in_frame    = 1'b0;
      seq_bit     = 1'b0;
      payload_xor = '0;
      mismatches  = 0;
      requests    = 0;
      out_bytes   = 0;
      frames      = 0;
      reg_writes  = 0;
    endfunction

    function void push_byte(logic [ByteWidth-1:0] b, logic last);
      out_item_t o;
      o.out_byte  = b;
      o.frame_end = last;
      expected_bytes.push_back(o);
    endfunction

    // Escape a byte that matches either the flag or the escape register
    function void push_stuffed(logic [ByteWidth-1:0] b);
      if (b == escape_byte || b == flag_byte) begin
        push_byte(escape_byte, 1'b0);
        push_byte(b ^ mask_byte, 1'b0);
      end else begin
        push_byte(b, 1'b0);
      end
    endfunction

    function void write_reg(cfg_reg_t idx, logic [ByteWidth-1:0] v);
      reg_writes++;
      case (idx)
        REG_FLAG:    flag_byte = v;
        REG_ESCAPE:  escape_byte = v;
        REG_MASK:    mask_byte = v;
        REG_ADDRESS: addr_byte = v;
        default: ;
      endcase
    endfunction

    // Note an accepted payload request and queue the bytes it yields
    function void add_payload(in_item_t item);
      logic [ByteWidth-1:0] ctrl;
      requests++;
      if (!in_frame) begin
        ctrl = ByteWidth'(seq_bit) << SeqShift;
        // header bytes go out unstuffed
        push_byte(flag_byte, 1'b0);
        push_byte(addr_byte, 1'b0);
        push_byte(ctrl, 1'b0);
        push_byte(addr_byte ^ ctrl, 1'b0);
        payload_xor = '0;
        in_frame    = 1'b1;
      end
      push_stuffed(item.data_byte);
      payload_xor = payload_xor ^ item.data_byte;
      if (item.end_of_packet) begin
        push_stuffed(payload_xor);
        push_byte(flag_byte, 1'b1);
        seq_bit     = ~seq_bit;
        payload_xor = '0;
        in_frame    = 1'b0;
        frames++;
      end
    endfunction

    // Compare one output byte with the oldest expectation
    function void check_out(out_item_t got);
      out_item_t want;
      out_bytes++;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected output byte %02h end %0b", $time, got.out_byte,
                   got.frame_end);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.frame_end !== want.frame_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: output mismatch, expected byte %02h end %0b, got %02h end %0b",
                   $time, want.out_byte, want.frame_end, got.out_byte, got.frame_end);
      end
    endfunction
  endclass

  localparam int CycleLimit = 300000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_reg_t  cfg_index = REG_FLAG;
  logic [7:0] cfg_data = '0;

  int send_idle = 19;
  int recv_idle = 59;
  int cycles = 0;

  framer_scoreboard sb = new();

  info_frame_stuffing_framer_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Watch all three handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.add_payload(in_data);
      if (out_valid && out_ready) sb.check_out(out_data);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Stall the output side at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // Offer one payload request, idling first at random, and hold it until taken
  task automatic send_item(logic [7:0] d, logic eop);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: d, end_of_packet: eop};
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait for every expected byte to come out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_reg_value();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Favour bytes that need escaping
  function automatic logic [7:0] pick_payload();
    case ($urandom_range(9))
      0, 1: return sb.flag_byte;
      2, 3: return sb.escape_byte;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic shuffle_config();
    logic [7:0] f;
    f = pick_reg_value();
    settle();
    write_reg(REG_FLAG, f);
    write_reg(REG_ESCAPE, ($urandom_range(3) == 0) ? f : pick_reg_value());
    write_reg(REG_MASK, pick_reg_value());
    write_reg(REG_ADDRESS, pick_reg_value());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Single-byte packets at both extremes, reset registers
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    // Flag and escape bytes inside the payload
    send_item(8'h7E, 1'b0);
    send_item(8'h7D, 1'b0);
    send_item(8'h55, 1'b0);
    send_item(8'hAA, 1'b1);
    // Check byte that equals the flag
    send_item(8'h7E, 1'b1);

    // Address equal to the flag: header stays unstuffed, both sequence values
    settle();
    write_reg(REG_ADDRESS, 8'h7E);
    send_item(8'h12, 1'b1);
    send_item(8'h34, 1'b1);

    // Change the mask in the middle of an open frame
    send_item(8'h7E, 1'b0);
    settle();
    write_reg(REG_MASK, 8'hFF);
    send_item(8'h7E, 1'b0);
    send_item(8'h81, 1'b1);

    // Flag and escape registers equal
    settle();
    write_reg(REG_FLAG, 8'h00);
    write_reg(REG_ESCAPE, 8'h00);
    send_item(8'h00, 1'b0);
    send_item(8'h01, 1'b1);

    // Register extremes, one way then the other
    settle();
    write_reg(REG_FLAG, 8'hFF);
    write_reg(REG_ESCAPE, 8'h00);
    write_reg(REG_MASK, 8'h00);
    write_reg(REG_ADDRESS, 8'h00);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    settle();
    write_reg(REG_FLAG, 8'h00);
    write_reg(REG_ESCAPE, 8'hFF);
    write_reg(REG_MASK, 8'hFF);
    write_reg(REG_ADDRESS, 8'hFF);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);

    // Random packets under three idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle = 19; recv_idle = 59; end
        1: begin send_idle = 59; recv_idle = 19; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      shuffle_config();
      for (int i = 0; i < 27; i++) begin
        if ($urandom_range(19) == 0) begin
          // occasional register change, often with a frame open
          settle();
          write_reg(cfg_reg_t'($urandom_range(3)), pick_reg_value());
        end
        send_item(pick_payload(), $urandom_range(3) == 0);
      end
    end

    settle();
    repeat (16) @(posedge clk);
    if (sb.expected_bytes.size() != 0) begin
      $display("%0d expected bytes never came out", sb.expected_bytes.size());
      sb.mismatches++;
    end
    $display("Covered %0d payload requests in %0d closed frames, %0d output bytes checked,",
             sb.requests, sb.frames, sb.out_bytes);
    $display("%0d register writes, %0d mismatches", sb.reg_writes, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
